### hw/rtl/tcw_pkg.sv
package tcw_pkg;

  // grid geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // field widths
  localparam int ADDR_W = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int COLOR_W = 4;
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] CELLS_A   = ADDR_W'(CELL_COUNT);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

  // commands
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // control bytes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // white-on-black space
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  // configuration register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_t;

endpackage

### hw/rtl/tcw_ram.sv
// simple dual-port RAM, one write and one registered read per cycle
module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/text_console_char_writer.sv
// Text console character writer over an 80x25 grid of 16-bit cells.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries put and read
// commands; output channel (out_valid_o / out_stall_i / out_data_o) returns
// exactly one result per transfer in, in order. Colors are set through the
// plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user is to write
// it only while idle, which the block does not enforce. Cells live in one
// dual-port RAM (one write, one registered read a cycle).
// Result path after an input transfer:
//   put without scroll : result registered at the accept edge
//   read               : RAM read data registered, then the result
//   put that scrolls   : copying 24 rows one cell per cycle (each
//                        write takes the registered read), then
//                        blanking the bottom row, then the result.
// One item is handled at a time.
// After reset a clearing pass writes 0x0F20 to every cell, one per cycle;
// no input is taken meanwhile, config writes are. Cursor resets to 0,
// foreground 15, background 0.
// A new item is taken only while the output register is empty or its
// result transfers in the same cycle; a stalled result simply holds.
module text_console_char_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tcw_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tcw_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata_i
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_BLANK = 3'd4;

  logic [2:0] state_q, state_d;

  // cursor kept as index plus row base and column, so no division is needed
  logic [tcw_pkg::ADDR_W-1:0] cursor_q, cursor_d;
  logic [tcw_pkg::ADDR_W-1:0] row_q, row_d;
  logic [tcw_pkg::COL_W-1:0]  col_q, col_d;

  logic [tcw_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic                       oob_q, oob_d;

  logic [tcw_pkg::COLOR_W-1:0] fg_q, bg_q;

  logic          out_vld_q, out_vld_d;
  tcw_pkg::out_t out_q, out_d;

  logic                       ram_we, ram_re;
  logic [tcw_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic                       accept;
  logic                       is_put;
  logic                       scroll;
  logic [tcw_pkg::CHAR_W-1:0] attr;
  logic [tcw_pkg::CELL_W-1:0] blank;

  assign attr  = {bg_q, fg_q};
  assign blank = {attr, tcw_pkg::CHAR_SPACE};

  assign in_stall_o = !((state_q == ST_IDLE) && (!out_vld_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;
  assign is_put     = (in_data_i.command == tcw_pkg::CMD_PUT);

  // cursor update for a put
  always_comb begin
    cursor_d = cursor_q;
    row_d    = row_q;
    col_d    = col_q;
    scroll   = 1'b0;
    if (accept && is_put) begin
      case (in_data_i.char_code)
        tcw_pkg::CHAR_BS: begin
          if (cursor_q != '0) begin
            cursor_d = cursor_q - 1'b1;
            if (col_q == '0) begin
              col_d = tcw_pkg::LAST_COL;
              row_d = row_q - tcw_pkg::COLS_A;
            end else begin
              col_d = col_q - 1'b1;
            end
          end
        end
        tcw_pkg::CHAR_CR: begin
          cursor_d = row_q;
          col_d    = '0;
        end
        tcw_pkg::CHAR_LF: begin
          col_d = '0;
          if (row_q == tcw_pkg::LAST_ROW) begin
            scroll   = 1'b1;
            cursor_d = row_q;
          end else begin
            row_d    = row_q + tcw_pkg::COLS_A;
            cursor_d = row_q + tcw_pkg::COLS_A;
          end
        end
        default: begin
          if (cursor_q == tcw_pkg::LAST_CELL) begin
            // ran off the grid: scroll and pull back one row
            scroll   = 1'b1;
            cursor_d = tcw_pkg::LAST_ROW;
            col_d    = '0;
          end else if (col_q == tcw_pkg::LAST_COL) begin
            col_d    = '0;
            row_d    = row_q + tcw_pkg::COLS_A;
            cursor_d = cursor_q + 1'b1;
          end else begin
            col_d    = col_q + 1'b1;
            cursor_d = cursor_q + 1'b1;
          end
        end
      endcase
    end
  end

  // RAM port steering and sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    oob_d     = oob_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = idx_q + tcw_pkg::COLS_A;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_CELL;
        idx_d     = idx_q + 1'b1;
        if (idx_q == tcw_pkg::LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!is_put) begin
            oob_d     = (in_data_i.cell_address >= tcw_pkg::CELLS_A);
            ram_re    = (in_data_i.cell_address < tcw_pkg::CELLS_A);
            ram_raddr = in_data_i.cell_address;
            state_d   = ST_RD;
          end else begin
            case (in_data_i.char_code) inside
              tcw_pkg::CHAR_BS: begin
                ram_we    = 1'b1;
                ram_waddr = cursor_d;
                ram_wdata = blank;
              end
              tcw_pkg::CHAR_CR, tcw_pkg::CHAR_LF: begin
                ram_we = 1'b0;
              end
              default: begin
                ram_we    = 1'b1;
                ram_waddr = cursor_q;
                ram_wdata = {attr, in_data_i.char_code};
              end
            endcase
            if (scroll) begin
              idx_d   = '0;
              state_d = ST_COPY;
            end else begin
              out_vld_d = 1'b1;
              out_d     = '{cursor_position: cursor_d, cell_data: '0, scrolled: 1'b0};
            end
          end
        end
      end
      ST_RD: begin
        out_vld_d = 1'b1;
        out_d     = '{cursor_position: cursor_q,
                      cell_data: oob_q ? '0 : ram_rdata,
                      scrolled: 1'b0};
        state_d   = ST_IDLE;
      end
      ST_COPY: begin
        // read cell idx+COLUMNS, write the one read last cycle to idx-1
        ram_re    = (idx_q < tcw_pkg::LAST_ROW);
        ram_we    = (idx_q != '0);
        ram_waddr = idx_q - 1'b1;
        ram_wdata = ram_rdata;
        if (idx_q == tcw_pkg::LAST_ROW) begin
          state_d = ST_BLANK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = blank;
        idx_d     = idx_q + 1'b1;
        if (idx_q == tcw_pkg::LAST_CELL) begin
          out_vld_d = 1'b1;
          out_d     = '{cursor_position: cursor_q, cell_data: '0, scrolled: 1'b1};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      idx_q     <= '0;
      oob_q     <= 1'b0;
      cursor_q  <= '0;
      row_q     <= '0;
      col_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      oob_q     <= oob_d;
      cursor_q  <= cursor_d;
      row_q     <= row_d;
      col_q     <= col_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'hF;
      bg_q <= 4'h0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcw_pkg::CFG_FG: fg_q <= cfg_wdata_i;
        tcw_pkg::CFG_BG: bg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  tcw_ram #(
    .DEPTH (tcw_pkg::CELL_COUNT),
    .WIDTH (tcw_pkg::CELL_W),
    .AW    (tcw_pkg::ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
